// ===== hdl/sbks_pkg.sv =====
package sbks_pkg;

    localparam int CAPACITY   = 16;
    localparam int NUM_STACKS = 4;

    // Slot pointers carry one extra code: CAPACITY itself means null.
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    localparam int OP_W     = 2;
    localparam int SEL_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_TOP   = 2'd2,
        OP_EMPTY = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic                     fire;
        op_t                      op;
        logic [SEL_W-1:0]         sel;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        status_t                  status;
        logic                     is_empty;
    } rsp_t;

endpackage

// ===== hdl/sbks_store.sv =====
module sbks_store
    import sbks_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    output rsp_t rsp
);

    logic [PTR_W-1:0]         stack_head_reg [NUM_STACKS];
    logic [PTR_W-1:0]         slot_link_reg  [CAPACITY];
    logic signed [DATA_W-1:0] slot_data_reg  [CAPACITY];
    logic [PTR_W-1:0]         free_head_reg;

    logic               sel_ok;
    logic [STK_W-1:0]   stk_idx;
    logic [PTR_W-1:0]   head;
    logic               has;
    logic               free_ok;
    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  free_slot;
    logic [SLOT_W-1:0]  link_addr;
    logic [PTR_W-1:0]   link_rd;
    logic               do_push;
    logic               do_pop;
    logic [PTR_W-1:0]   head_after;

    assign sel_ok    = 32'(req.sel) < NUM_STACKS;
    assign stk_idx   = STK_W'(req.sel);
    assign head      = stack_head_reg[stk_idx];
    assign has       = head < NULL_PTR;
    assign free_ok   = free_head_reg < NULL_PTR;
    assign head_slot = head[SLOT_W-1:0];
    assign free_slot = free_head_reg[SLOT_W-1:0];

    // A push follows the free list, a pop follows the stack, so one link port is enough.
    assign link_addr = (req.op == OP_PUSH) ? free_slot : head_slot;
    assign link_rd   = slot_link_reg[link_addr];

    assign do_push = sel_ok && (req.op == OP_PUSH) && free_ok;
    assign do_pop  = sel_ok && (req.op == OP_POP) && has;

    always_comb
    begin
        head_after = head;
        if (do_push)
        begin
            head_after = free_head_reg;
        end
        else if (do_pop)
        begin
            head_after = link_rd;
        end
    end

    always_comb
    begin
        rsp.data     = '0;
        rsp.status   = ST_OK;
        rsp.is_empty = !sel_ok || !(head_after < NULL_PTR);
        unique case (req.op) inside
            OP_PUSH:
            begin
                if (!sel_ok || !free_ok)
                begin
                    rsp.status = ST_OVERFLOW;
                end
            end
            OP_POP, OP_TOP:
            begin
                if (!sel_ok || !has)
                begin
                    rsp.status = ST_UNDERFLOW;
                    rsp.data   = '1;
                end
                else
                begin
                    rsp.data = slot_data_reg[head_slot];
                end
            end
            default:
            begin
                rsp.data = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_link_reg[i] <= PTR_W'(i + 1);
            end
            for (int s = 0; s < NUM_STACKS; s++)
            begin
                stack_head_reg[s] <= NULL_PTR;
            end
            free_head_reg <= '0;
        end
        else if (req.fire)
        begin
            if (do_push)
            begin
                free_head_reg           <= link_rd;
                slot_link_reg[free_slot] <= has ? head : NULL_PTR;
                stack_head_reg[stk_idx] <= free_head_reg;
            end
            else if (do_pop)
            begin
                stack_head_reg[stk_idx] <= link_rd;
                slot_link_reg[head_slot] <= free_head_reg;
                free_head_reg           <= head;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.fire && do_push)
        begin
            slot_data_reg[free_slot] <= req.value;
        end
    end

endmodule

// ===== hdl/shared_buffer_k_stacks.sv =====
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tdata: operation, stack_sel, value
// m_axis    out        m_tvalid/m_tready  m_tdata: data_out, status, is_empty
//
// One word in, one word out; a taken word sits in the input register, then moves to
// the result register, from which it leaves on the output channel.
// A new word is taken every cycle while the output side keeps up: the stack and
// free-list update is combinational between the input and result registers.
// After reset all stacks are empty and every slot sits on the free list.
// When the result register is stalled, one more word waits in the input register.
module shared_buffer_k_stacks
    import sbks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[1:0], stack_sel[3:2], value[35:4], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // data_out[31:0], status[33:32], is_empty[34], zero pad
);

    logic                     in_v_reg;
    logic                     in_v_next;
    op_t                      op_reg;
    logic [SEL_W-1:0]         sel_reg;
    logic signed [DATA_W-1:0] value_reg;

    logic                     out_v_reg;
    logic                     out_v_next;
    logic signed [DATA_W-1:0] data_reg;
    status_t                  status_reg;
    logic                     empty_reg;

    logic advance;
    logic take;
    req_t req;
    rsp_t rsp;

    assign advance  = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !in_v_reg || advance;
    assign take     = s_tvalid && s_tready;

    assign in_v_next  = take || (in_v_reg && !advance);
    assign out_v_next = advance || (out_v_reg && !m_tready);

    assign req.fire  = advance;
    assign req.op    = op_reg;
    assign req.sel   = sel_reg;
    assign req.value = value_reg;

    sbks_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg    <= op_t'(s_tdata[1:0]);
            sel_reg   <= s_tdata[3:2];
            value_reg <= s_tdata[35:4];
        end
        if (advance)
        begin
            data_reg   <= rsp.data;
            status_reg <= rsp.status;
            empty_reg  <= rsp.is_empty;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'b0, empty_reg, status_reg, data_reg};

    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_v_reg)
        else $error("processed word did not reach the result register");

    a_underflow_shape : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg == ST_UNDERFLOW) |-> (data_reg == '1 && empty_reg))
        else $error("underflow result must carry -1 and an empty stack");

    a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_v_reg && out_v_reg && !m_tready))
        else $error("input stalled while a register was free");

    a_overflow_no_data : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg == ST_OVERFLOW) |-> (data_reg == '0))
        else $error("overflow result must carry zero data");

endmodule

// ===== verif/tb_shared_buffer_k_stacks.sv =====
`timescale 1ns / 1ps

module tb_shared_buffer_k_stacks;
    import sbks_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 2000;
    localparam int CHUNK       = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    shared_buffer_k_stacks dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Shadow copy of the slot store, the link store and the list heads.
    logic signed [DATA_W-1:0] slot_val [CAPACITY];
    logic [PTR_W-1:0]         slot_next [CAPACITY];
    logic [PTR_W-1:0]         stack_top [NUM_STACKS];
    logic [PTR_W-1:0]         free_ptr;

    rsp_t expected_rsp [$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   tx_gap_max = 16;
    int   rx_gap_max = 16;
    int   rx_hold_cycles = 0;

    task automatic init_stack_model();
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_val[i]  = '0;
            slot_next[i] = (i == CAPACITY - 1) ? NULL_PTR : PTR_W'(i + 1);
        end
        for (int s = 0; s < NUM_STACKS; s++)
            stack_top[s] = NULL_PTR;
        free_ptr = '0;
    endtask

    function automatic rsp_t apply_stack_op(input op_t op, input logic [SEL_W-1:0] sel,
                                            input logic signed [DATA_W-1:0] val);
        rsp_t              r;
        logic [PTR_W-1:0]  head;
        logic [SLOT_W-1:0] head_slot;
        logic [SLOT_W-1:0] slot;
        logic              has;
        r.data     = '0;
        r.status   = ST_OK;
        r.is_empty = 1'b1;
        if (int'(sel) < NUM_STACKS)
        begin
            head      = stack_top[sel];
            head_slot = head[SLOT_W-1:0];
            has       = (head < CAPACITY);
            case (op) inside
                OP_PUSH:
                    if (free_ptr >= CAPACITY)
                        r.status = ST_OVERFLOW;
                    else
                    begin
                        slot            = free_ptr[SLOT_W-1:0];
                        free_ptr        = slot_next[slot];
                        slot_next[slot] = has ? head : NULL_PTR;
                        stack_top[sel]  = PTR_W'(slot);
                        slot_val[slot]  = val;
                    end
                OP_POP, OP_TOP:
                    if (!has)
                    begin
                        r.status = ST_UNDERFLOW;
                        r.data   = -1;
                    end
                    else
                    begin
                        r.data = slot_val[head_slot];
                        if (op == OP_POP)
                        begin
                            stack_top[sel]       = slot_next[head_slot];
                            slot_next[head_slot] = free_ptr;
                            free_ptr             = head;
                        end
                    end
                default: ;
            endcase
            r.is_empty = (stack_top[sel] >= CAPACITY);
        end
        else
        begin
            // A selector past the last stack behaves as a stack that is always empty and full.
            if (op == OP_PUSH)
                r.status = ST_OVERFLOW;
            else if (op inside {OP_POP, OP_TOP})
            begin
                r.status = ST_UNDERFLOW;
                r.data   = -1;
            end
        end
        return r;
    endfunction

    // Offers one word and returns at the rising edge where it is taken.
    task automatic send_word(input op_t op, input logic [SEL_W-1:0] sel,
                             input logic signed [DATA_W-1:0] val);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, val, sel, op};
        do
            @(posedge clk);
        while (!s_tready);
        expected_rsp.push_back(apply_stack_op(op, sel, val));
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic op_t pick_op(input int push_pct, input int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return OP_PUSH;
        if (roll < push_pct + pop_pct)
            return OP_POP;
        if (roll[0])
            return OP_TOP;
        return OP_EMPTY;
    endfunction

    task automatic empty_all_stacks();
        for (int s = 0; s < NUM_STACKS; s++)
            while (stack_top[s] != NULL_PTR)
                send_word(OP_POP, SEL_W'(s), $urandom());
    endtask

    task automatic test_empty_after_reset();
        for (int s = 0; s < NUM_STACKS; s++)
            send_word(OP_EMPTY, SEL_W'(s), $urandom());
    endtask

    task automatic test_underflow();
        send_word(OP_POP, 2'd0, 32'sh7FFF_FFFF);
        send_word(OP_TOP, 2'd1, -32'sd1);
    endtask

    task automatic test_value_extremes();
        send_word(OP_PUSH, 2'd0, 32'sh7FFF_FFFF);
        send_word(OP_PUSH, 2'd0, 32'sh8000_0000);
        send_word(OP_PUSH, 2'd3, -32'sd1);
        send_word(OP_PUSH, 2'd2, 32'sd0);
        send_word(OP_TOP,  2'd0, 32'sd0);
        send_word(OP_EMPTY, 2'd1, 32'sd0);
        send_word(OP_POP,  2'd0, 32'sd0);
        send_word(OP_POP,  2'd0, 32'sd0);
        send_word(OP_POP,  2'd0, 32'sd0);
        send_word(OP_POP,  2'd3, 32'sd0);
        send_word(OP_TOP,  2'd2, 32'sd0);
        send_word(OP_POP,  2'd2, 32'sd0);
        send_word(OP_EMPTY, 2'd2, 32'sd0);
    endtask

    // Exhausts the free list over random stacks, pushes into the full store, empties every stack and pushes once more.
    task automatic test_fill_and_overflow();
        while (free_ptr != NULL_PTR)
            send_word(OP_PUSH, SEL_W'($urandom_range(0, 3)), $urandom());
        for (int i = 0; i < 4; i++)
            send_word(OP_PUSH, SEL_W'(i), $urandom());
        send_word(OP_TOP, SEL_W'($urandom_range(0, 3)), $urandom());
        empty_all_stacks();
        send_word(OP_PUSH, SEL_W'($urandom_range(0, 3)), $urandom());
    endtask

    // The output side holds off while words keep coming, so the input must stall.
    task automatic test_output_stall();
        tx_gap_max     = 0;
        rx_hold_cycles = 300;
        for (int i = 0; i < 40; i++)
            send_word(pick_op(50, 30), SEL_W'($urandom_range(0, 3)), $urandom());
        wait_all_results();
        tx_gap_max = 16;
    endtask

    task automatic test_random_mix();
        int push_pct;
        int pop_pct;
        for (int c = 0; c < RANDOM_WORDS / CHUNK; c++)
        begin
            if (c % 2 == 0)
            begin
                push_pct = 65;
                pop_pct  = 20;
            end
            else
            begin
                push_pct = 25;
                pop_pct  = 55;
            end
            case ($urandom_range(0, 4))
                0: begin tx_gap_max = 0;  rx_gap_max = 0;  end
                1: begin tx_gap_max = 16; rx_gap_max = 16; end
                2: begin tx_gap_max = 16; rx_gap_max = 0;  end
                3: begin tx_gap_max = 0;  rx_gap_max = 16; end
                default: begin tx_gap_max = 3; rx_gap_max = 3; end
            endcase
            for (int i = 0; i < CHUNK; i++)
                send_word(pick_op(push_pct, pop_pct), SEL_W'($urandom_range(0, 3)), $urandom());
            if (c % 8 == 7)
                wait_all_results();
        end
        tx_gap_max = 16;
        rx_gap_max = 16;
    endtask

    // Result side: random ready gaps, an occasional long hold-off, and the comparison.
    initial
    begin
        int   gap;
        int   hold;
        rsp_t want;
        rsp_t got;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                hold           = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.data     = m_tdata[31:0];
            got.status   = status_t'(m_tdata[33:32]);
            got.is_empty = m_tdata[34];
            if (expected_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected word data %h status %0d empty %b",
                             $realtime, got.data, got.status, got.is_empty);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (got.data !== want.data || got.status !== want.status
                    || got.is_empty !== want.is_empty)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected %h/%0d/%b, got %h/%0d/%b",
                                 $realtime, want.data, want.status, want.is_empty,
                                 got.data, got.status, got.is_empty);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        init_stack_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_after_reset();
        test_underflow();
        test_value_extremes();
        wait_all_results();
        test_fill_and_overflow();
        test_output_stall();
        test_random_mix();

        wait_all_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sbks_pkg.sv
hdl/sbks_store.sv
hdl/shared_buffer_k_stacks.sv
verif/tb_shared_buffer_k_stacks.sv
